[sv/afs_pkg.sv]
package afs_pkg;

    // Default table depth; the top level takes it as a parameter.
    localparam int MAX_FRAMES_DEF = 256;

    // Wide enough to hold any table depth up to 4096 for compares.
    localparam int WIDE_W = 13;

    localparam int KIND_W     = 2;
    localparam int NOW_W      = 32;
    localparam int INDEX_W    = 8;
    localparam int DELAY_W    = 16;
    localparam int COUNT_W    = 9;
    localparam int SPEED_W    = 9;
    localparam int FRAME_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // A 16-bit delay times 100 fits in 23 bits.
    localparam int DIVIDEND_W = 23;

    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_INTRO_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTRO_PRESENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED         = 2'd3;

    localparam logic [SPEED_W-1:0]    SPEED_RESET   = 9'd75;
    localparam logic [DELAY_W-1:0]    DEFAULT_DELAY = 16'd100;
    localparam logic [DIVIDEND_W-1:0] SCALE         = 23'd100;

endpackage

[sv/afs_ram.sv]
module afs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/afs_div.sv]
module afs_div
    import afs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [SPEED_W-1:0]    i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [SPEED_W-1:0]    r_rem;
    logic [SPEED_W-1:0]    r_dsr;
    logic [DIVIDEND_W-1:0] r_quo;

    logic [SPEED_W:0] rem_shift;
    logic [SPEED_W:0] rem_sub;
    logic             fits;

    // Restoring division, one quotient bit per cycle, MSB first.
    assign rem_shift = {r_rem, r_quo[DIVIDEND_W-1]};
    assign rem_sub   = rem_shift - {1'b0, r_dsr};
    assign fits      = rem_shift >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dsr <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= fits ? rem_sub[SPEED_W-1:0] : rem_shift[SPEED_W-1:0];
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[sv/animation_frame_scheduler.sv]
// Channel   Direction  Handshake                     Payload
// item in   input      i_start & !o_busy             i_kind, i_now_ms, i_table_select,
//                                                    i_table_index, i_delay_value
// result    output     o_done (one-cycle strobe)     o_draw_frame, o_frame_number,
//                                                    o_from_intro, o_swap_red_blue,
//                                                    o_is_playing
// config    input      i_cfg_valid & o_cfg_ready     i_cfg_index, i_cfg_data
//
// Start, stop and table write items, and timer updates that need no delay check,
// strobe their result the cycle after acceptance. A timer update that has to check
// the frame delay reads the delay table (state S_READ) and then runs the bit-serial
// divider (state S_DIV); its result strobes after the divider is done. One item is
// worked on at a time. Reset is synchronous and active low; the delay tables are
// not cleared. The result receiver cannot stall, so o_busy depends only on work.
module animation_frame_scheduler
    import afs_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [NOW_W-1:0]      i_now_ms,
    input  logic                  i_table_select,
    input  logic [INDEX_W-1:0]    i_table_index,
    input  logic [DELAY_W-1:0]    i_delay_value,
    output logic                  o_done,
    output logic                  o_draw_frame,
    output logic [INDEX_W-1:0]    o_frame_number,
    output logic                  o_from_intro,
    output logic                  o_swap_red_blue,
    output logic                  o_is_playing,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_FRAMES);
    localparam logic [WIDE_W-1:0] MAXF = WIDE_W'(MAX_FRAMES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic [NOW_W-1:0]   r_last, n_last;
    logic [NOW_W-1:0]   r_now, n_now;
    logic               r_intro, n_intro;
    logic               r_loop, n_loop;
    logic               r_active, n_active;
    logic               r_playing, n_playing;
    logic               r_done, n_done;
    logic               r_draw, r_from_intro, r_swap;
    logic [INDEX_W-1:0] r_fnum;

    logic [COUNT_W-1:0] r_intro_cnt;
    logic [COUNT_W-1:0] r_main_cnt;
    logic               r_intro_present;
    logic [SPEED_W-1:0] r_speed;

    logic                  accept;
    logic                  emit;
    logic [WIDE_W-1:0]     intro_clamp, main_clamp, act_count;
    logic                  in_table;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic                  wr_ok;
    logic [DELAY_W-1:0]    rd_intro, rd_main;
    logic [DELAY_W-1:0]    entry, delay_ms;
    logic [DIVIDEND_W-1:0] dividend;
    logic [SPEED_W-1:0]    speed_eff;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] quotient;
    logic [NOW_W-1:0]      elapsed;
    logic [FRAME_W-1:0]    frame_inc;

    assign accept = i_start && (r_state == S_IDLE);

    assign intro_clamp = ({4'b0, r_intro_cnt} > MAXF) ? MAXF : {4'b0, r_intro_cnt};
    assign main_clamp  = ({4'b0, r_main_cnt} > MAXF) ? MAXF : {4'b0, r_main_cnt};
    assign act_count   = r_intro ? intro_clamp : main_clamp;

    // Table addresses; anything at or beyond the depth is gated off.
    assign in_table = {4'b0, r_frame} < MAXF;
    assign rd_addr  = AW'({4'b0, r_frame});
    assign wr_addr  = AW'({5'b0, i_table_index});
    assign wr_ok    = accept && (i_kind == KIND_WRITE) && ({5'b0, i_table_index} < MAXF);

    afs_ram #(
        .WIDTH (DELAY_W),
        .DEPTH (MAX_FRAMES)
    ) u_intro_ram (
        .i_clk   (i_clk),
        .i_we    (wr_ok && !i_table_select),
        .i_waddr (wr_addr),
        .i_wdata (i_delay_value),
        .i_raddr (rd_addr),
        .o_rdata (rd_intro)
    );

    afs_ram #(
        .WIDTH (DELAY_W),
        .DEPTH (MAX_FRAMES)
    ) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (wr_ok && i_table_select),
        .i_waddr (wr_addr),
        .i_wdata (i_delay_value),
        .i_raddr (rd_addr),
        .o_rdata (rd_main)
    );

    always_comb begin
        entry = '0;
        if (in_table) begin
            entry = r_intro ? rd_intro : rd_main;
        end
        if (entry == '0) begin
            entry = DEFAULT_DELAY;
        end
    end

    assign dividend  = DIVIDEND_W'(entry) * SCALE;
    assign speed_eff = (r_speed == '0) ? SPEED_W'(1) : r_speed;

    afs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_READ),
        .i_dividend (dividend),
        .i_divisor  (speed_eff),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    assign delay_ms  = quotient[DELAY_W-1:0];
    assign elapsed   = r_now - r_last;
    assign frame_inc = r_frame + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_frame   = r_frame;
        n_last    = r_last;
        n_now     = r_now;
        n_intro   = r_intro;
        n_loop    = r_loop;
        n_active  = r_active;
        n_playing = r_playing;
        n_done    = 1'b0;
        emit      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_now = i_now_ms;
                    unique case (i_kind)
                        KIND_UPDATE: begin
                            // A looping set of one frame or none never moves on.
                            if (r_playing && r_active &&
                                !((act_count <= WIDE_W'(1)) && r_loop)) begin
                                n_state = S_READ;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        KIND_START: begin
                            n_playing = 1'b1;
                            n_done    = 1'b1;
                            if (r_intro_present) begin
                                n_intro = 1'b1;
                                if (intro_clamp == '0) begin
                                    n_active = 1'b0;
                                    n_loop   = 1'b0;
                                end else begin
                                    n_active = 1'b1;
                                    n_loop   = 1'b0;
                                    n_frame  = '0;
                                    n_last   = i_now_ms;
                                    emit     = 1'b1;
                                end
                            end else begin
                                n_intro = 1'b0;
                                if (main_clamp == '0) begin
                                    n_active = 1'b0;
                                    n_loop   = 1'b0;
                                end else begin
                                    n_active = 1'b1;
                                    n_loop   = 1'b1;
                                    n_frame  = '0;
                                    n_last   = i_now_ms;
                                    emit     = 1'b1;
                                end
                            end
                        end
                        KIND_STOP: begin
                            n_playing = 1'b0;
                            n_active  = 1'b0;
                            n_done    = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    if (elapsed >= {16'b0, delay_ms}) begin
                        n_frame = frame_inc;
                        if ({4'b0, frame_inc} >= act_count) begin
                            if (r_loop) begin
                                n_frame = '0;
                                n_last  = r_now;
                                emit    = 1'b1;
                            end else if (r_intro) begin
                                // Intro is over: hand over to the main set.
                                n_intro = 1'b0;
                                if (main_clamp == '0) begin
                                    n_active = 1'b0;
                                    n_loop   = 1'b0;
                                end else begin
                                    n_active = 1'b1;
                                    n_loop   = 1'b1;
                                    n_frame  = '0;
                                    n_last   = r_now;
                                    emit     = 1'b1;
                                end
                            end else begin
                                n_playing = 1'b0;
                            end
                        end else begin
                            n_last = r_now;
                            emit   = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_frame         <= '0;
            r_last          <= '0;
            r_intro         <= 1'b0;
            r_loop          <= 1'b0;
            r_active        <= 1'b0;
            r_playing       <= 1'b0;
            r_done          <= 1'b0;
            r_intro_cnt     <= '0;
            r_main_cnt      <= '0;
            r_intro_present <= 1'b0;
            r_speed         <= SPEED_RESET;
        end else begin
            r_state   <= n_state;
            r_frame   <= n_frame;
            r_last    <= n_last;
            r_intro   <= n_intro;
            r_loop    <= n_loop;
            r_active  <= n_active;
            r_playing <= n_playing;
            r_done    <= n_done;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_INTRO_COUNT:   r_intro_cnt     <= i_cfg_data;
                    CFG_MAIN_COUNT:    r_main_cnt      <= i_cfg_data;
                    CFG_INTRO_PRESENT: r_intro_present <= i_cfg_data[0];
                    CFG_SPEED:         r_speed         <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now <= n_now;
        if (n_done) begin
            r_draw       <= emit;
            r_fnum       <= emit ? n_frame[INDEX_W-1:0] : '0;
            r_from_intro <= emit && n_intro;
            r_swap       <= emit && !n_intro;
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_draw_frame    = r_draw;
    assign o_frame_number  = r_fnum;
    assign o_from_intro    = r_from_intro;
    assign o_swap_red_blue = r_swap;
    assign o_is_playing    = r_playing;
    assign o_cfg_ready     = 1'b1;

endmodule

[verif/animation_frame_scheduler_tb.sv]
`timescale 1ns / 1ps

module animation_frame_scheduler_tb;
    import afs_pkg::*;

    localparam int DEPTH       = MAX_FRAMES_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 137;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [NOW_W-1:0]   now;
        logic               sel;
        logic [INDEX_W-1:0] idx;
        logic [DELAY_W-1:0] val;
    } t_cmd;

    typedef struct packed {
        logic               draw;
        logic [INDEX_W-1:0] frame;
        logic               intro;
        logic               swap;
        logic               playing;
    } t_frame_res;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] reg_val;
        t_cmd                  cmd;
        bit                    typed;
        t_frame_res            want;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic                  o_busy;
    logic [KIND_W-1:0]     i_kind = '0;
    logic [NOW_W-1:0]      i_now_ms = '0;
    logic                  i_table_select = 1'b0;
    logic [INDEX_W-1:0]    i_table_index = '0;
    logic [DELAY_W-1:0]    i_delay_value = '0;
    logic                  o_done;
    logic                  o_draw_frame;
    logic [INDEX_W-1:0]    o_frame_number;
    logic                  o_from_intro;
    logic                  o_swap_red_blue;
    logic                  o_is_playing;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    animation_frame_scheduler dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_kind          (i_kind),
        .i_now_ms        (i_now_ms),
        .i_table_select  (i_table_select),
        .i_table_index   (i_table_index),
        .i_delay_value   (i_delay_value),
        .o_done          (o_done),
        .o_draw_frame    (o_draw_frame),
        .o_frame_number  (o_frame_number),
        .o_from_intro    (o_from_intro),
        .o_swap_red_blue (o_swap_red_blue),
        .o_is_playing    (o_is_playing),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Scheduler state as the predictor sees it.
    logic [DELAY_W-1:0]    intro_tbl [DEPTH];
    logic [DELAY_W-1:0]    main_tbl [DEPTH];
    bit                    intro_wr [DEPTH];
    bit                    main_wr [DEPTH];
    logic [FRAME_W-1:0]    frame_ctr = '0;
    logic [NOW_W-1:0]      last_ms = '0;
    bit                    in_intro, loop_set, set_on, play_on;
    logic [COUNT_W-1:0]    m_intro_cnt = '0;
    logic [COUNT_W-1:0]    m_main_cnt = '0;
    logic [SPEED_W-1:0]    m_speed = SPEED_RESET;
    bit                    m_intro_en;

    t_frame_res            due_frames [$];
    t_plan_row             plan [$];
    int                    errors, results_seen, items_sent, frames_drawn;
    int                    handoffs, reg_writes, cycle_count;

    function automatic int unsigned clamp_cnt(logic [COUNT_W-1:0] c);
        return (c > DEPTH) ? DEPTH : c;
    endfunction

    function automatic int unsigned active_cnt();
        return clamp_cnt(in_intro ? m_intro_cnt : m_main_cnt);
    endfunction

    // True when a timer update would look up the current frame's delay.
    function automatic bit reads_entry();
        return play_on && set_on && !(active_cnt() <= 1 && loop_set);
    endfunction

    function automatic bit entry_written();
        return in_intro ? intro_wr[frame_ctr] : main_wr[frame_ctr];
    endfunction

    function automatic int unsigned scaled_delay();
        int unsigned entry, sp;
        entry = 0;
        if (frame_ctr < DEPTH) begin
            entry = in_intro ? intro_tbl[frame_ctr] : main_tbl[frame_ctr];
        end
        if (entry == 0) begin
            entry = DEFAULT_DELAY;
        end
        sp = (m_speed == 0) ? 1 : m_speed;
        return ((entry * SCALE) / sp) & 32'hFFFF;
    endfunction

    function automatic bit enter_set(int unsigned cnt, bit loops, logic [NOW_W-1:0] now);
        if (cnt == 0) begin
            set_on = 1'b0;
            loop_set = 1'b0;
            return 1'b0;
        end
        set_on = 1'b1;
        loop_set = loops;
        frame_ctr = '0;
        last_ms = now;
        return 1'b1;
    endfunction

    function automatic t_frame_res advance_scheduler(t_cmd c);
        t_frame_res  r;
        bit          drew;
        int unsigned cnt;
        drew = 1'b0;
        case (c.kind)
            KIND_UPDATE: begin
                if (reads_entry() && (c.now - last_ms) >= scaled_delay()) begin
                    cnt = active_cnt();
                    frame_ctr = frame_ctr + 1'b1;
                    if (frame_ctr >= cnt && !loop_set) begin
                        if (in_intro) begin
                            in_intro = 1'b0;
                            handoffs++;
                            drew = enter_set(clamp_cnt(m_main_cnt), 1'b1, c.now);
                        end else begin
                            play_on = 1'b0;
                        end
                    end else begin
                        if (frame_ctr >= cnt) begin
                            frame_ctr = '0;
                        end
                        drew = 1'b1;
                        last_ms = c.now;
                    end
                end
            end
            KIND_START: begin
                in_intro = m_intro_en;
                if (m_intro_en) begin
                    drew = enter_set(clamp_cnt(m_intro_cnt), 1'b0, c.now);
                end else begin
                    drew = enter_set(clamp_cnt(m_main_cnt), 1'b1, c.now);
                end
                play_on = 1'b1;
            end
            KIND_STOP: begin
                play_on = 1'b0;
                set_on = 1'b0;
            end
            default: begin
                if (c.sel) begin
                    main_tbl[c.idx] = c.val;
                    main_wr[c.idx] = 1'b1;
                end else begin
                    intro_tbl[c.idx] = c.val;
                    intro_wr[c.idx] = 1'b1;
                end
            end
        endcase
        r.draw = drew;
        r.frame = drew ? frame_ctr[INDEX_W-1:0] : '0;
        r.intro = drew && in_intro;
        r.swap = drew && !in_intro;
        r.playing = play_on;
        return r;
    endfunction

    function automatic t_plan_row cmd_row(logic [KIND_W-1:0] kind, logic [NOW_W-1:0] now,
                                          logic sel, logic [INDEX_W-1:0] idx,
                                          logic [DELAY_W-1:0] val);
        t_plan_row r;
        r = '{default: '0};
        r.cmd = '{kind, now, sel, idx, val};
        return r;
    endfunction

    // Swap follows from the set: main frames always swap red and blue.
    function automatic t_plan_row typed(t_plan_row r, bit draw, logic [INDEX_W-1:0] frame,
                                        bit intro, bit playing);
        r.typed = 1'b1;
        r.want = '{draw, frame, intro, draw && !intro, playing};
        return r;
    endfunction

    function automatic t_plan_row cfg_row(logic [CFG_IDX_W-1:0] sel,
                                          logic [CFG_DATA_W-1:0] val);
        t_plan_row r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.reg_sel = sel;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(9))
            0: return 9'd0;
            1: return 9'd1;
            2: return 9'd256;
            3: return 9'd511;
            default: return COUNT_W'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic t_cmd next_cmd();
        t_cmd        c;
        int unsigned roll, d, delta;
        c.kind = KIND_UPDATE;
        c.now = $urandom;
        c.sel = 1'($urandom_range(1));
        c.idx = INDEX_W'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15));
        case ($urandom_range(7))
            0: c.val = '0;
            1: c.val = '1;
            2, 3: c.val = DELAY_W'($urandom);
            default: c.val = DELAY_W'($urandom_range(1, 300));
        endcase
        // The delay of the frame on show must be in its table before any update
        // reads it.
        if (reads_entry() && !entry_written()) begin
            c.kind = KIND_WRITE;
            c.sel = !in_intro;
            c.idx = frame_ctr[INDEX_W-1:0];
            return c;
        end
        roll = $urandom_range(99);
        if (reads_entry()) begin
            if (roll < 72) begin
                d = scaled_delay();
                case ($urandom_range(5))
                    0: delta = (d == 0) ? 0 : $urandom_range(d - 1);
                    1: delta = (d == 0) ? 0 : d - 1;
                    2, 3: delta = d;
                    4: delta = d + $urandom_range(50);
                    default: delta = $urandom;
                endcase
                c.now = last_ms + delta;
            end else if (roll < 84) begin
                c.kind = KIND_WRITE;
            end else if (roll < 90) begin
                c.kind = KIND_START;
            end else if (roll < 94) begin
                c.kind = KIND_STOP;
            end
        end else begin
            if (roll < 40) begin
                c.kind = KIND_START;
            end else if (roll < 70) begin
                c.kind = KIND_WRITE;
            end else if (roll >= 90) begin
                c.kind = KIND_STOP;
            end
        end
        return c;
    endfunction

    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at result %0d, %s: got %0h, expected %0h",
                 results_seen, what, got, want);
        errors++;
    endtask

    task automatic send_cmd(t_cmd c, bit use_typed, t_frame_res want);
        t_frame_res predicted;
        @(negedge i_clk);
        i_kind <= c.kind;
        i_now_ms <= c.now;
        i_table_select <= c.sel;
        i_table_index <= c.idx;
        i_delay_value <= c.val;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        predicted = advance_scheduler(c);
        due_frames.push_back(use_typed ? want : predicted);
        items_sent++;
        if (predicted.draw) begin
            frames_drawn++;
        end
    endtask

    task automatic hold_off(int pct);
        while ($urandom_range(99) < pct) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (due_frames.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] sel, logic [CFG_DATA_W-1:0] val);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (sel)
            CFG_INTRO_COUNT:   m_intro_cnt = val;
            CFG_MAIN_COUNT:    m_main_cnt = val;
            CFG_INTRO_PRESENT: m_intro_en = val[0];
            default:           m_speed = val;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_frame_res want;
        if (i_rst_n && o_done) begin
            if (due_frames.size() == 0) begin
                flag_mismatch("result with nothing expected", 0, 0);
            end else begin
                want = due_frames.pop_front();
                if (o_draw_frame !== want.draw)
                    flag_mismatch("draw_frame", o_draw_frame, want.draw);
                if (o_frame_number !== want.frame)
                    flag_mismatch("frame_number", o_frame_number, want.frame);
                if (o_from_intro !== want.intro)
                    flag_mismatch("from_intro", o_from_intro, want.intro);
                if (o_swap_red_blue !== want.swap)
                    flag_mismatch("swap_red_blue", o_swap_red_blue, want.swap);
                if (o_is_playing !== want.playing)
                    flag_mismatch("is_playing", o_is_playing, want.playing);
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, due_frames.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int idle_pct [4];
        t_frame_res none;
        idle_pct = '{0, 50, 0, 22};
        none = '0;

        // After reset nothing plays and both counts are zero.
        plan.push_back(typed(cmd_row(KIND_UPDATE, 32'h0, 1'b0, 8'd0, 16'h0), 0, 0, 0, 0));
        plan.push_back(typed(cmd_row(KIND_STOP, '1, 1'b1, '1, '1), 0, 0, 0, 0));
        plan.push_back(typed(cmd_row(KIND_START, 32'h0, 1'b0, 8'd0, 16'h0), 0, 0, 0, 1));
        plan.push_back(typed(cmd_row(KIND_UPDATE, '1, 1'b0, 8'd0, 16'h0), 0, 0, 0, 1));
        plan.push_back(typed(cmd_row(KIND_WRITE, 32'h0, 1'b0, 8'd0, 16'h0), 0, 0, 0, 1));
        plan.push_back(typed(cmd_row(KIND_WRITE, 32'h0, 1'b0, 8'd1, 16'h1), 0, 0, 0, 1));
        plan.push_back(typed(cmd_row(KIND_WRITE, '1, 1'b0, 8'd255, '1), 0, 0, 0, 1));
        plan.push_back(typed(cmd_row(KIND_WRITE, 32'h0, 1'b1, 8'd0, '1), 0, 0, 0, 1));
        plan.push_back(typed(cmd_row(KIND_WRITE, 32'h0, 1'b1, 8'd1, 16'h0), 0, 0, 0, 1));
        plan.push_back(typed(cmd_row(KIND_WRITE, 32'h0, 1'b1, 8'd255, 16'h1), 0, 0, 0, 1));
        plan.push_back(typed(cmd_row(KIND_STOP, 32'h0, 1'b0, 8'd0, 16'h0), 0, 0, 0, 0));
        // Intro of two frames, main count above the table depth, zero speed.
        plan.push_back(cfg_row(CFG_INTRO_COUNT, 9'd2));
        plan.push_back(cfg_row(CFG_MAIN_COUNT, 9'd511));
        plan.push_back(cfg_row(CFG_INTRO_PRESENT, 9'd1));
        plan.push_back(cfg_row(CFG_SPEED, 9'd0));
        plan.push_back(typed(cmd_row(KIND_START, 32'hFFFF_FFF0, 1'b0, 8'd0, 16'h0),
                             1, 0, 1, 1));
        // Elapsed time wraps through zero here.
        plan.push_back(cmd_row(KIND_UPDATE, 32'h0000_26FF, 1'b0, 8'd0, 16'h0));
        plan.push_back(cmd_row(KIND_UPDATE, 32'h0000_2700, 1'b0, 8'd0, 16'h0));
        plan.push_back(cmd_row(KIND_UPDATE, 32'h0000_2764, 1'b0, 8'd0, 16'h0));
        plan.push_back(cmd_row(KIND_UPDATE, 32'h0001_2700, 1'b0, 8'd0, 16'h0));
        plan.push_back(typed(cmd_row(KIND_STOP, 32'h0, 1'b0, 8'd0, 16'h0), 0, 0, 0, 0));
        // A looping set of one frame never advances.
        plan.push_back(cfg_row(CFG_MAIN_COUNT, 9'd1));
        plan.push_back(cfg_row(CFG_INTRO_PRESENT, 9'd0));
        plan.push_back(cfg_row(CFG_SPEED, 9'd511));
        plan.push_back(typed(cmd_row(KIND_START, 32'h1234_5678, 1'b0, 8'd0, 16'h0),
                             1, 0, 0, 1));
        plan.push_back(typed(cmd_row(KIND_UPDATE, '1, 1'b0, 8'd0, 16'h0), 0, 0, 0, 1));
        // An empty intro set leaves playback on but inactive.
        plan.push_back(cfg_row(CFG_INTRO_PRESENT, 9'd1));
        plan.push_back(cfg_row(CFG_INTRO_COUNT, 9'd0));
        plan.push_back(typed(cmd_row(KIND_START, 32'h0, 1'b0, 8'd0, 16'h0), 0, 0, 0, 1));
        plan.push_back(typed(cmd_row(KIND_UPDATE, '1, 1'b0, 8'd0, 16'h0), 0, 0, 0, 1));
        plan.push_back(typed(cmd_row(KIND_STOP, 32'h0, 1'b0, 8'd0, 16'h0), 0, 0, 0, 0));
        // One intro frame handing off to an empty main set.
        plan.push_back(cfg_row(CFG_INTRO_COUNT, 9'd1));
        plan.push_back(cfg_row(CFG_MAIN_COUNT, 9'd0));
        plan.push_back(cfg_row(CFG_SPEED, 9'd400));
        plan.push_back(typed(cmd_row(KIND_START, 32'd100, 1'b0, 8'd0, 16'h0), 1, 0, 1, 1));
        plan.push_back(cmd_row(KIND_UPDATE, 32'd125, 1'b0, 8'd0, 16'h0));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[n]) begin
            if (plan[n].is_cfg) begin
                write_reg(plan[n].reg_sel, plan[n].reg_val);
            end else begin
                hold_off(30);
                send_cmd(plan[n].cmd, plan[n].typed, plan[n].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            write_reg(CFG_INTRO_COUNT, pick_count());
            write_reg(CFG_MAIN_COUNT, pick_count());
            write_reg(CFG_INTRO_PRESENT, CFG_DATA_W'($urandom_range(1)));
            case ($urandom_range(7))
                0: write_reg(CFG_SPEED, 9'd0);
                1: write_reg(CFG_SPEED, 9'd1);
                2: write_reg(CFG_SPEED, 9'd400);
                3: write_reg(CFG_SPEED, 9'd511);
                default: write_reg(CFG_SPEED, CFG_DATA_W'($urandom_range(1, 400)));
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(49) == 0) begin
                    wait_drained();
                end
                hold_off(idle_pct[p % 4]);
                send_cmd(next_cmd(), 1'b0, none);
            end
        end

        wait_drained();
        repeat (30) @(posedge i_clk);
        $display("Run covered %0d items and %0d results under %0d register writes,",
                 items_sent, results_seen, reg_writes);
        $display("with %0d frames drawn and %0d intro-to-main handoffs.",
                 frames_drawn, handoffs);
        if (errors == 0 && due_frames.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
